FILE: rtl/rbap_pkg.sv
// ----------------------------------------------------------------------------
// rbap_pkg
// shared types and constants for the array-of-bulk-strings parser
// ----------------------------------------------------------------------------
package rbap_pkg;

    localparam int unsigned RBAP_QUEUE_DEPTH = 4;

    localparam int unsigned ARG_COUNT_W  = 21;
    localparam int unsigned BULK_LEN_W   = 30;
    localparam int unsigned ARG_INDEX_W  = 20;
    localparam int unsigned CFG_DATA_W   = 30;
    localparam int unsigned OUT_TDATA_W  = 32;

    localparam logic [ARG_COUNT_W-1:0] MAX_ARG_COUNT_RST  = 21'h10_0000;
    localparam logic [BULK_LEN_W-1:0]  MAX_BULK_LEN_RST   = 30'h2000_0000;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_MAX_ARG_COUNT   = 1'b0,
        CFG_MAX_BULK_LENGTH = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_END   = 2'd1,
        KIND_EMPTY = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_BAD_START  = 3'd0,
        ERR_NON_DIGIT  = 3'd1,
        ERR_MISSING_LF = 3'd2,
        ERR_NO_DOLLAR  = 3'd3,
        ERR_DATA_CRLF  = 3'd4,
        ERR_OVER_LIMIT = 3'd5
    } err_t;

    typedef struct packed {
        kind_t                  kind;
        logic [7:0]             data;
        logic [ARG_INDEX_W-1:0] index;
        logic                   last;
        err_t                   code;
    } rec_t;

    // queue handshake between front and back
    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

FILE: rtl/resp_bulk_array_parser.sv
// ----------------------------------------------------------------------------
// resp_bulk_array_parser
// byte-serial parser for commands sent as an array of bulk strings
// ----------------------------------------------------------------------------
//  channel   dir  handshake                   contents
//  s_axis    in   s_axis_tvalid/tready        tdata[7:0] in_byte
//  m_axis    out  m_axis_tvalid/tready        tdata data_byte, arg_index,
//                                             error_code; tuser result_kind;
//                                             tlast last_arg
//  cfg       in   cfg_we (no handshake)       cfg_index, cfg_wdata
//
//  one byte per cycle; the parser updates its state and pushes at most one
//  word into a small queue in the same cycle; the output register is loaded
//  from the queue. s_axis_tready drops only when the queue is full, i.e.
//  after the master side has stalled for a few words. reset clears the
//  parser to idle and both limits to their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module resp_bulk_array_parser
    import rbap_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = RBAP_QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [0:0]             cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] in_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] data_byte, [27:8] arg_index, [30:28] error_code, [31] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]             m_axis_tuser,   // [1:0] result_kind
    output logic                   m_axis_tlast    // last_arg
);

    q_ctrl_t q_ctrl;
    q_stat_t q_stat;
    rec_t    wr_rec;
    rec_t    rd_rec;
    logic    q_push;
    logic    q_pop;

    assign q_ctrl.push = q_push;
    assign q_ctrl.pop  = q_pop;

    rbap_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_rec     (wr_rec)
    );

    rbap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_ctrl (q_ctrl),
        .wr_rec (wr_rec),
        .rd_rec (rd_rec),
        .q_stat (q_stat)
    );

    rbap_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .rd_rec    (rd_rec),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

FILE: rtl/rbap_front.sv
// ----------------------------------------------------------------------------
// rbap_front
// byte parser: walks the command syntax and pushes one result word per event
// ----------------------------------------------------------------------------
module rbap_front
    import rbap_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [0:0]             cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_byte,
    input  q_stat_t                q_stat,
    output logic                   q_push,
    output rec_t                   q_rec
);

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam int unsigned PROD_W   = BULK_LEN_W + 4;

    typedef enum logic [8:0] {
        PH_IDLE    = 9'b000000001,
        PH_COUNT   = 9'b000000010,
        PH_CNT_LF  = 9'b000000100,
        PH_DOLLAR  = 9'b000001000,
        PH_LEN     = 9'b000010000,
        PH_LEN_LF  = 9'b000100000,
        PH_DATA    = 9'b001000000,
        PH_DATA_CR = 9'b010000000,
        PH_DATA_LF = 9'b100000000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [BULK_LEN_W-1:0]  accum_reg, accum_next;
    logic [ARG_COUNT_W-1:0] args_rem_reg, args_rem_next;
    logic [BULK_LEN_W-1:0]  bytes_rem_reg, bytes_rem_next;
    logic [ARG_INDEX_W-1:0] cur_arg_reg, cur_arg_next;
    logic                   resync_reg, resync_next;
    logic [ARG_COUNT_W-1:0] max_args_reg;
    logic [BULK_LEN_W-1:0]  max_len_reg;

    logic                   accept;
    logic                   is_digit;
    logic [PROD_W-1:0]      accum_x10;
    logic [BULK_LEN_W-1:0]  limit;
    logic                   over;
    logic                   last_arg;
    logic [BULK_LEN_W-1:0]  bytes_dec;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);

    // times ten as shift and add, plus the digit
    assign accum_x10 = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                     + {{(PROD_W-4){1'b0}}, in_byte[3:0]};
    assign limit     = (phase_reg == PH_COUNT)
                     ? {{(BULK_LEN_W-ARG_COUNT_W){1'b0}}, max_args_reg} : max_len_reg;
    assign over      = accum_x10 > {4'b0000, limit};
    assign last_arg  = args_rem_reg <= ARG_COUNT_W'(1);
    assign bytes_dec = bytes_rem_reg - BULK_LEN_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_args_reg <= MAX_ARG_COUNT_RST;
            max_len_reg  <= MAX_BULK_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_ARG_COUNT:   max_args_reg <= cfg_wdata[ARG_COUNT_W-1:0];
                CFG_MAX_BULK_LENGTH: max_len_reg  <= cfg_wdata[BULK_LEN_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        accum_next     = accum_reg;
        args_rem_next  = args_rem_reg;
        bytes_rem_next = bytes_rem_reg;
        cur_arg_next   = cur_arg_reg;
        resync_next    = resync_reg;
        q_push         = 1'b0;
        q_rec          = '0;

        if (accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (in_byte == CH_STAR)
                    begin
                        resync_next = 1'b0;
                        accum_next  = '0;
                        phase_next  = PH_COUNT;
                    end
                    else if (!resync_reg)
                    begin
                        q_push      = 1'b1;
                        q_rec.kind  = KIND_ERROR;
                        q_rec.code  = ERR_BAD_START;
                    end
                end
                PH_COUNT, PH_LEN:
                begin
                    if (in_byte == CH_CR)
                        phase_next = (phase_reg == PH_COUNT) ? PH_CNT_LF : PH_LEN_LF;
                    else if (!is_digit)
                    begin
                        q_push     = 1'b1;
                        q_rec.kind = KIND_ERROR;
                        q_rec.code = ERR_NON_DIGIT;
                    end
                    else if (over)
                    begin
                        q_push     = 1'b1;
                        q_rec.kind = KIND_ERROR;
                        q_rec.code = ERR_OVER_LIMIT;
                    end
                    else
                        accum_next = accum_x10[BULK_LEN_W-1:0];
                end
                PH_CNT_LF:
                begin
                    if (in_byte != CH_LF)
                    begin
                        q_push     = 1'b1;
                        q_rec.kind = KIND_ERROR;
                        q_rec.code = ERR_MISSING_LF;
                    end
                    else if (accum_reg == '0)
                    begin
                        phase_next = PH_IDLE;
                        q_push     = 1'b1;
                        q_rec.kind = KIND_EMPTY;
                    end
                    else
                    begin
                        args_rem_next = accum_reg[ARG_COUNT_W-1:0];
                        cur_arg_next  = '0;
                        accum_next    = '0;
                        phase_next    = PH_DOLLAR;
                    end
                end
                PH_DOLLAR:
                begin
                    if (in_byte != CH_DOLLAR)
                    begin
                        q_push     = 1'b1;
                        q_rec.kind = KIND_ERROR;
                        q_rec.code = ERR_NO_DOLLAR;
                    end
                    else
                    begin
                        accum_next = '0;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN_LF:
                begin
                    if (in_byte != CH_LF)
                    begin
                        q_push     = 1'b1;
                        q_rec.kind = KIND_ERROR;
                        q_rec.code = ERR_MISSING_LF;
                    end
                    else
                    begin
                        bytes_rem_next = accum_reg;
                        accum_next     = '0;
                        phase_next     = (accum_reg == '0) ? PH_DATA_CR : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    bytes_rem_next = bytes_dec;
                    if (bytes_dec == '0)
                        phase_next = PH_DATA_CR;
                    q_push      = 1'b1;
                    q_rec.kind  = KIND_BYTE;
                    q_rec.data  = in_byte;
                    q_rec.index = cur_arg_reg;
                end
                PH_DATA_CR:
                begin
                    if (in_byte != CH_CR)
                    begin
                        q_push     = 1'b1;
                        q_rec.kind = KIND_ERROR;
                        q_rec.code = ERR_DATA_CRLF;
                    end
                    else
                        phase_next = PH_DATA_LF;
                end
                PH_DATA_LF:
                begin
                    if (in_byte != CH_LF)
                    begin
                        q_push     = 1'b1;
                        q_rec.kind = KIND_ERROR;
                        q_rec.code = ERR_DATA_CRLF;
                    end
                    else
                    begin
                        args_rem_next = args_rem_reg - ARG_COUNT_W'(1);
                        cur_arg_next  = cur_arg_reg + ARG_INDEX_W'(1);
                        phase_next    = last_arg ? PH_IDLE : PH_DOLLAR;
                        q_push        = 1'b1;
                        q_rec.kind    = KIND_END;
                        q_rec.index   = cur_arg_reg;
                        q_rec.last    = last_arg;
                    end
                end
                default:
                begin
                    phase_next  = PH_IDLE;
                    resync_next = 1'b0;
                end
            endcase

            // any error sends the parser back to idle in drop mode
            if (q_push && (q_rec.kind == KIND_ERROR))
            begin
                phase_next  = PH_IDLE;
                resync_next = 1'b1;
                accum_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            accum_reg     <= '0;
            args_rem_reg  <= '0;
            bytes_rem_reg <= '0;
            cur_arg_reg   <= '0;
            resync_reg    <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            accum_reg     <= accum_next;
            args_rem_reg  <= args_rem_next;
            bytes_rem_reg <= bytes_rem_next;
            cur_arg_reg   <= cur_arg_next;
            resync_reg    <= resync_next;
        end
    end

endmodule

FILE: rtl/rbap_queue.sv
// ----------------------------------------------------------------------------
// rbap_queue
// short result queue between the parser and the output stage
// ----------------------------------------------------------------------------
module rbap_queue
    import rbap_pkg::*;
#(
    parameter int unsigned DEPTH = RBAP_QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_ctrl_t q_ctrl,
    input  rec_t    wr_rec,
    output rec_t    rd_rec,
    output q_stat_t q_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rec_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_stat.full  = count_reg == CNT_W'(DEPTH);
    assign q_stat.empty = count_reg == '0;
    assign do_push      = q_ctrl.push && !q_stat.full;
    assign do_pop       = q_ctrl.pop && !q_stat.empty;
    assign rd_rec       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/rbap_back.sv
// ----------------------------------------------------------------------------
// rbap_back
// output stage: drains the queue into a registered master stream word
// ----------------------------------------------------------------------------
module rbap_back
    import rbap_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  q_stat_t                q_stat,
    input  rec_t                   rd_rec,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_TDATA_W-1:0] out_data,
    output logic [1:0]             out_user,
    output logic                   out_last
);

    logic                   valid_reg, valid_next;
    logic [OUT_TDATA_W-1:0] data_reg;
    logic [1:0]             user_reg;
    logic                   last_reg;
    logic                   load;

    // refill when the register is empty or its word leaves this cycle
    assign load       = !q_stat.empty && (!valid_reg || out_ready);
    assign q_pop      = load;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {1'b0, rd_rec.code, rd_rec.index, rd_rec.data};
            user_reg <= rd_rec.kind;
            last_reg <= rd_rec.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_user  = user_reg;
    assign out_last  = last_reg;

endmodule
